// ----- sv/rhh_pkg.sv -----
// shared types and constants of the robin hood hash table
`timescale 1ns / 1ps
`default_nettype none

package rhh_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int HASH_W   = 64;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT   = 3'd0,
        FN_FIND     = 3'd1,
        FN_REMOVE   = 3'd2,
        FN_INS_FIND = 3'd3,
        FN_CLEAR    = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    // write enables of the slot store
    typedef struct packed {
        logic key;
        logic val;
        logic pdist;
    } t_st_we;

endpackage

`default_nettype wire

// ----- sv/rhh_req_if.sv -----
// request channel of the hash table
`timescale 1ns / 1ps
`default_nettype none

interface rhh_req_if;
    logic                          valid;
    logic                          ready;
    logic [rhh_pkg::FUNC_W-1:0]    func;
    logic [rhh_pkg::KEY_W-1:0]     key_word;
    logic [rhh_pkg::HASH_W-1:0]    key_hash;
    logic [rhh_pkg::VALUE_W-1:0]   new_value;

    modport source (output valid, func, key_word, key_hash, new_value, input ready);
    modport sink   (input valid, func, key_word, key_hash, new_value, output ready);
endinterface

`default_nettype wire

// ----- sv/rhh_rsp_if.sv -----
// result channel of the hash table
`timescale 1ns / 1ps
`default_nettype none

interface rhh_rsp_if #(
    parameter int IDX_W = $clog2(rhh_pkg::CAPACITY_DEF),
    parameter int CNT_W = $clog2(rhh_pkg::CAPACITY_DEF + 1)
);
    logic                          valid;
    logic                          ready;
    logic [rhh_pkg::STATUS_W-1:0]  status;
    logic [IDX_W-1:0]              slot_pos;
    logic [rhh_pkg::VALUE_W-1:0]   slot_value;
    logic [CNT_W-1:0]              entry_count;

    modport source (output valid, status, slot_pos, slot_value, entry_count, input ready);
    modport sink   (input valid, status, slot_pos, slot_value, entry_count, output ready);
endinterface

`default_nettype wire

// ----- sv/rhh_home.sv -----
// home slot unit: hash modulo capacity, mask or one hash byte per cycle
`timescale 1ns / 1ps
`default_nettype none

module rhh_home #(
    parameter int CAPACITY = rhh_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rhh_pkg::HASH_W-1:0]  i_hash,
    output logic                             o_done,
    output logic [$clog2(CAPACITY)-1:0]      o_home
);
    localparam int IW    = $clog2(CAPACITY);
    localparam int BYTES = rhh_pkg::HASH_W / 8;
    localparam int NW    = $clog2(BYTES);
    localparam int TW    = IW + 8;
    localparam int MW    = 9;
    localparam int PW    = TW + MW;
    localparam bit POW2  = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [IW:0]   CAP_X = (IW + 1)'(CAPACITY);
    localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);
    // floor of 2^TW / capacity, quotient estimate is at most one short
    localparam logic [MW-1:0] RECIP = MW'((1 << TW) / CAPACITY);
    localparam logic [NW-1:0] LAST  = NW'(BYTES - 1);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [NW-1:0]              r_cnt, n_cnt;
    logic [rhh_pkg::HASH_W-1:0] r_sh, n_sh;
    logic [IW-1:0]              r_rem, n_rem;
    logic [TW-1:0]              w_t;
    logic [PW-1:0]              w_prod;
    logic [MW-1:0]              w_q;
    logic [TW-1:0]              w_sub;
    logic [IW:0]                w_r;

    assign w_t    = {r_rem, r_sh[rhh_pkg::HASH_W-1 -: 8]};
    assign w_prod = PW'(w_t) * PW'(RECIP);
    assign w_q    = w_prod[PW-1 -: MW];
    assign w_sub  = w_t - (TW'(w_q) * CAP_T);
    assign w_r    = w_sub[IW:0];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        if (i_start) begin
            if (POW2) begin
                n_rem  = i_hash[IW-1:0];
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_sh   = i_hash;
                n_rem  = '0;
                n_cnt  = '0;
            end
        end else if (r_busy) begin
            // reciprocal estimate, then one correcting subtract
            n_rem = (w_r >= CAP_X) ? IW'(w_r - CAP_X) : IW'(w_r);
            n_sh  = {r_sh[rhh_pkg::HASH_W-9:0], 8'h00};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

`default_nettype wire

// ----- sv/rhh_store.sv -----
// slot store: key, value and distance memories with per-slot written bits
`timescale 1ns / 1ps
`default_nettype none

module rhh_store #(
    parameter int CAPACITY = rhh_pkg::CAPACITY_DEF,
    parameter int KW       = rhh_pkg::KEY_BITS_DEF,
    parameter int VW       = rhh_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clr,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_addr,
    input  wire rhh_pkg::t_st_we               i_we,
    input  wire logic [KW-1:0]                 i_key,
    input  wire logic [VW-1:0]                 i_val,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_dist,
    output logic [KW-1:0]                      o_key,
    output logic [VW-1:0]                      o_val,
    output logic [$clog2(CAPACITY)-1:0]        o_dist
);
    localparam int IW = $clog2(CAPACITY);

    logic [KW-1:0] m_key  [CAPACITY];
    logic [VW-1:0] m_val  [CAPACITY];
    logic [IW-1:0] m_dist [CAPACITY];

    logic [CAPACITY-1:0] r_written;
    logic [KW-1:0]       r_rd_key;
    logic [VW-1:0]       r_rd_val;
    logic [IW-1:0]       r_rd_dist;
    logic                r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we.key)   m_key[i_addr]  <= i_key;
        if (i_we.val)   m_val[i_addr]  <= i_val;
        if (i_we.pdist) m_dist[i_addr] <= i_dist;
        r_rd_key  <= m_key[i_addr];
        r_rd_val  <= m_val[i_addr];
        r_rd_dist <= m_dist[i_addr];
        r_rd_ok   <= r_written[i_addr];
    end

    // a slot never written since reset or clear reads as distance zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_written <= '0;
        end else if (i_we.pdist) begin
            r_written[i_addr] <= 1'b1;
        end
    end

    assign o_key  = r_rd_key;
    assign o_val  = r_rd_val;
    assign o_dist = r_rd_ok ? r_rd_dist : '0;

endmodule

`default_nettype wire

// ----- sv/robin_hood_hash_table.sv -----
// robin hood hash table top level: probe sequencer around the slot store
// requests arrive on i_req (func, key_word, key_hash, new_value) and each gives
// one result on o_rsp (status, slot_pos, slot_value, entry_count).
// i_req.ready is high only while the sequencer is idle; one request at a time.
// steps: S_IDLE accepts, S_HOME waits for the home slot (ready in the cycle
// after acceptance when the capacity is a power of two, else one hash byte
// per cycle), then S_RD and S_EVAL per probed slot (store read, then compare
// and write back), then S_DONE loads the output register. full, clear and
// unknown functions go from S_HOME straight to S_DONE.
// the store has one port, so each probe is a read followed by a write.
// the output register holds a result until taken; the next request may be
// accepted meanwhile and waits at its end while the previous result stalls.
// reset (synchronous, active low) and the clear function empty the table:
// occupied marks, written marks, count and maximum distance.
`timescale 1ns / 1ps
`default_nettype none

module robin_hood_hash_table #(
    parameter int CAPACITY   = rhh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = rhh_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = rhh_pkg::VALUE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rhh_req_if.sink    i_req,
    rhh_rsp_if.source  o_rsp
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = KEY_BITS;
    localparam int VW = (VALUE_BITS > rhh_pkg::VALUE_W) ? rhh_pkg::VALUE_W : VALUE_BITS;
    localparam logic [IW-1:0] POS_LAST = IW'(CAPACITY - 1);
    localparam logic [CW:0]   CAP_X    = (CW + 1)'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HOME = 5'b00010,
        S_RD   = 5'b00100,
        S_EVAL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [rhh_pkg::FUNC_W-1:0] r_func, n_func;
    logic [KW-1:0]              r_key, n_key;
    logic [VW-1:0]              r_nv, n_nv;
    logic [IW-1:0]              r_pos, n_pos;
    logic [IW-1:0]              r_dist, n_dist;
    logic [IW-1:0]              r_max, n_max;
    logic [CW-1:0]              r_count, n_count;
    logic [CAPACITY-1:0]        r_occ, n_occ;
    logic [KW-1:0]              r_ck, n_ck;
    logic [VW-1:0]              r_cv, n_cv;
    logic                       r_landed, n_landed;
    logic [IW-1:0]              r_land_pos, n_land_pos;
    rhh_pkg::t_status           r_status, n_status;
    logic [IW-1:0]              r_where, n_where;
    logic [VW-1:0]              r_val, n_val;
    logic                       r_out_valid, n_out_valid;
    rhh_pkg::t_status           r_o_status, n_o_status;
    logic [IW-1:0]              r_o_index, n_o_index;
    logic [VW-1:0]              r_o_value, n_o_value;
    logic [CW-1:0]              r_o_count, n_o_count;

    logic                       w_accept;
    logic                       w_home_done;
    logic [IW-1:0]              w_home;
    rhh_pkg::t_st_we            w_we;
    logic                       w_clr;
    logic [KW-1:0]              w_st_key;
    logic [VW-1:0]              w_st_val;
    logic [IW-1:0]              w_st_dist;
    logic                       w_or_find;
    logic                       w_lookup;
    logic                       w_last;
    logic [IW-1:0]              w_pos_next;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_or_find  = r_func == rhh_pkg::FN_INS_FIND;
    assign w_lookup   = (r_func == rhh_pkg::FN_FIND) || (r_func == rhh_pkg::FN_REMOVE);
    assign w_last     = r_dist == POS_LAST;
    assign w_pos_next = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;

    rhh_home #(
        .CAPACITY (CAPACITY)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_hash  (i_req.key_hash),
        .o_done  (w_home_done),
        .o_home  (w_home)
    );

    rhh_store #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .VW       (VW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_clr),
        .i_addr  (r_pos),
        .i_we    (w_we),
        .i_key   (r_ck),
        .i_val   (r_cv),
        .i_dist  (r_dist),
        .o_key   (w_st_key),
        .o_val   (w_st_val),
        .o_dist  (w_st_dist)
    );

    always_comb begin
        logic       landed_now;
        logic [IW-1:0] land_pos_now;
        logic       step;

        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_nv        = r_nv;
        n_pos       = r_pos;
        n_dist      = r_dist;
        n_max       = r_max;
        n_count     = r_count;
        n_occ       = r_occ;
        n_ck        = r_ck;
        n_cv        = r_cv;
        n_landed    = r_landed;
        n_land_pos  = r_land_pos;
        n_status    = r_status;
        n_where     = r_where;
        n_val       = r_val;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_index   = r_o_index;
        n_o_value   = r_o_value;
        n_o_count   = r_o_count;
        w_we        = '0;
        w_clr       = 1'b0;
        landed_now  = r_landed;
        land_pos_now = r_land_pos;
        step        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func  = i_req.func;
                    n_key   = i_req.key_word[KW-1:0];
                    n_nv    = i_req.new_value[VW-1:0];
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (w_home_done) begin
                    n_pos    = w_home;
                    n_dist   = '0;
                    n_ck     = r_key;
                    n_cv     = r_nv;
                    n_landed = 1'b0;
                    n_where  = '0;
                    n_val    = '0;
                    case (r_func)
                        rhh_pkg::FN_INSERT, rhh_pkg::FN_INS_FIND: begin
                            if ({r_count, 1'b0} > CAP_X) begin
                                n_status = rhh_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        rhh_pkg::FN_FIND, rhh_pkg::FN_REMOVE: begin
                            n_state = S_RD;
                        end
                        rhh_pkg::FN_CLEAR: begin
                            w_clr    = 1'b1;
                            n_occ    = '0;
                            n_count  = '0;
                            n_max    = '0;
                            n_ck     = '0;
                            n_cv     = '0;
                            n_status = rhh_pkg::ST_CLEARED;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_status = rhh_pkg::ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_lookup) begin
                    if (!(w_st_dist >= r_dist || r_dist < r_max)) begin
                        n_status = rhh_pkg::ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else if (r_occ[r_pos] && w_st_key == r_ck) begin
                        n_where = r_pos;
                        n_val   = w_st_val;
                        if (r_func == rhh_pkg::FN_REMOVE) begin
                            n_occ[r_pos] = 1'b0;
                            n_count      = r_count - 1'b1;
                            n_status     = rhh_pkg::ST_REMOVED;
                        end else begin
                            n_status = rhh_pkg::ST_FOUND;
                        end
                        n_state = S_DONE;
                    end else begin
                        step = 1'b1;
                    end
                end else if (!r_occ[r_pos]) begin
                    // empty slot: the carried entry lands here
                    w_we         = '{key: 1'b1, val: 1'b1, pdist: 1'b1};
                    n_occ[r_pos] = 1'b1;
                    n_count      = r_count + 1'b1;
                    if (r_dist > r_max) n_max = r_dist;
                    n_status = rhh_pkg::ST_INSERTED;
                    n_where  = r_landed ? r_land_pos : r_pos;
                    n_val    = r_nv;
                    n_state  = S_DONE;
                end else if (w_st_dist >= r_dist) begin
                    if (w_st_key == r_ck) begin
                        if (!r_landed) begin
                            n_where = r_pos;
                            if (w_or_find) begin
                                n_status = rhh_pkg::ST_FOUND;
                                n_val    = w_st_val;
                            end else begin
                                w_we.val = 1'b1;
                                n_status = rhh_pkg::ST_UPDATED;
                                n_val    = r_cv;
                            end
                        end else begin
                            // displaced key met its own copy: drop the carried entry
                            w_we.val = !w_or_find;
                            n_status = rhh_pkg::ST_INSERTED;
                            n_where  = r_land_pos;
                            n_val    = r_nv;
                        end
                        n_state = S_DONE;
                    end else begin
                        step = 1'b1;
                    end
                end else begin
                    // richer entry found: swap and carry the displaced one on
                    w_we = '{key: 1'b1, val: 1'b1, pdist: 1'b1};
                    if (r_dist > r_max) n_max = r_dist;
                    if (!r_landed) begin
                        landed_now   = 1'b1;
                        land_pos_now = r_pos;
                    end
                    n_landed   = landed_now;
                    n_land_pos = land_pos_now;
                    n_ck       = w_st_key;
                    n_cv       = w_st_val;
                    step       = 1'b1;
                end

                if (step) begin
                    if (w_last) begin
                        n_state = S_DONE;
                        if (w_lookup) begin
                            n_status = rhh_pkg::ST_NOT_FOUND;
                        end else if (landed_now) begin
                            n_status = rhh_pkg::ST_INSERTED;
                            n_where  = land_pos_now;
                            n_val    = r_nv;
                        end else begin
                            n_status = rhh_pkg::ST_FULL;
                        end
                    end else begin
                        n_dist  = r_dist + 1'b1;
                        n_pos   = w_pos_next;
                        n_state = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_count   = r_count;
                    if (r_status inside {rhh_pkg::ST_NOT_FOUND, rhh_pkg::ST_FULL,
                                         rhh_pkg::ST_CLEARED}) begin
                        n_o_index = '0;
                        n_o_value = '0;
                    end else begin
                        n_o_index = r_where;
                        n_o_value = r_val;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= '0;
            r_count     <= '0;
            r_occ       <= '0;
            r_ck        <= '0;
            r_cv        <= '0;
            r_landed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max       <= n_max;
            r_count     <= n_count;
            r_occ       <= n_occ;
            r_ck        <= n_ck;
            r_cv        <= n_cv;
            r_landed    <= n_landed;
            r_out_valid <= n_out_valid;
        end
        r_func     <= n_func;
        r_key      <= n_key;
        r_nv       <= n_nv;
        r_pos      <= n_pos;
        r_dist     <= n_dist;
        r_land_pos <= n_land_pos;
        r_status   <= n_status;
        r_where    <= n_where;
        r_val      <= n_val;
        r_o_status <= n_o_status;
        r_o_index  <= n_o_index;
        r_o_value  <= n_o_value;
        r_o_count  <= n_o_count;
    end

    assign i_req.ready       = r_state == S_IDLE;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.slot_pos    = r_o_index;
    assign o_rsp.slot_value  = rhh_pkg::VALUE_W'(r_o_value);
    assign o_rsp.entry_count = r_o_count;

    // count tracks the occupied marks exactly
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_occ) == int'(r_count))
        else $error("entry count differs from occupied marks");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= CAPACITY)
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == rhh_pkg::ST_CLEARED) |-> (r_count == '0 && r_occ == '0))
        else $error("clear left entries behind");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("new request taken while one is in progress");

endmodule

`default_nettype wire

// ----- tb/robin_hood_hash_table_test.sv -----
// testbench of the robin hood hash table: directed table, then random requests checked by a predictor
`timescale 1ns / 1ps

module robin_hood_hash_table_test;

    localparam int SLOTS     = 64;
    localparam int RAND_REQS = 750;
    localparam int POOL      = 48;
    localparam int WDOG_MAX  = 6000;
    localparam logic [rhh_pkg::FUNC_W-1:0] FN_RSVD_5 = 3'd5;
    localparam logic [rhh_pkg::FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [rhh_pkg::FUNC_W-1:0] FN_RSVD_7 = 3'd7;
    localparam logic [63:0] ONES64 = '1;

    typedef struct packed {
        rhh_pkg::t_status status;
        logic [5:0]       idx;
        logic [31:0]      value;
        logic [6:0]       count;
    } t_answer;

    typedef struct {
        logic [rhh_pkg::FUNC_W-1:0] func;
        logic [63:0]                key;
        logic [63:0]                hash;
        logic [31:0]                value;
        bit                         typed;
        t_answer                    answer;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rhh_req_if req ();
    rhh_rsp_if rsp ();

    robin_hood_hash_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #6 i_clk = ~i_clk;

    // predictor copy of the table
    logic [63:0] tab_key [SLOTS];
    logic [31:0] tab_val [SLOTS];
    int          tab_dist [SLOTS];
    bit          tab_occ [SLOTS];
    int          max_dist;
    int          n_occ;

    t_answer answer_q [$];
    int      errors;
    bit      hold_off;
    bit      quiet;
    int      idle_cycles;

    function automatic void wipe_table();
        for (int i = 0; i < SLOTS; i++) begin
            tab_key[i] = '0;
            tab_val[i] = '0;
            tab_dist[i] = 0;
            tab_occ[i] = 1'b0;
        end
        max_dist = 0;
        n_occ = 0;
    endfunction

    function automatic bit probe_for(input logic [63:0] key, input int home, output int where);
        int pos;
        int span;
        pos = home;
        span = 0;
        where = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!(tab_dist[pos] >= span || span < max_dist)) break;
            if (tab_occ[pos] && tab_key[pos] == key) begin
                where = pos;
                return 1'b1;
            end
            span++;
            pos = (pos + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic rhh_pkg::t_status place_key(input logic [63:0] key,
                                                   input logic [31:0] value,
                                                   input int home, input bit or_find,
                                                   output int where, output logic [31:0] val);
        int pos;
        int span;
        int landed;
        bit has_landed;
        logic [63:0] ck;
        logic [31:0] cv;
        logic [63:0] k;
        logic [31:0] v;
        pos = home;
        span = 0;
        landed = 0;
        has_landed = 1'b0;
        ck = key;
        cv = value;
        where = 0;
        val = '0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!tab_occ[pos]) begin
                tab_key[pos] = ck;
                tab_val[pos] = cv;
                tab_dist[pos] = span;
                if (span > max_dist) max_dist = span;
                tab_occ[pos] = 1'b1;
                n_occ++;
                if (!has_landed) begin
                    landed = pos;
                    has_landed = 1'b1;
                end
                break;
            end else if (tab_dist[pos] >= span) begin
                if (tab_key[pos] == ck) begin
                    if (!has_landed) begin
                        where = pos;
                        if (or_find) begin
                            val = tab_val[pos];
                            return rhh_pkg::ST_FOUND;
                        end
                        tab_val[pos] = cv;
                        val = cv;
                        return rhh_pkg::ST_UPDATED;
                    end
                    // displaced entry met its own key further on: drop it
                    if (!or_find) tab_val[pos] = cv;
                    break;
                end
            end else begin
                k = tab_key[pos];
                v = tab_val[pos];
                tab_key[pos] = ck;
                tab_val[pos] = cv;
                tab_dist[pos] = span;
                if (span > max_dist) max_dist = span;
                if (!has_landed) begin
                    landed = pos;
                    has_landed = 1'b1;
                end
                ck = k;
                cv = v;
            end
            span++;
            pos = (pos + 1) % SLOTS;
        end
        where = landed;
        val = has_landed ? tab_val[landed] : '0;
        return has_landed ? rhh_pkg::ST_INSERTED : rhh_pkg::ST_FULL;
    endfunction

    function automatic t_answer apply_request(input logic [rhh_pkg::FUNC_W-1:0] func,
                                              input logic [63:0] key,
                                              input logic [63:0] hash,
                                              input logic [31:0] value);
        t_answer a;
        int home;
        int where;
        logic [31:0] val;
        home = int'(hash % SLOTS);
        where = 0;
        val = '0;
        a.status = rhh_pkg::ST_NOT_FOUND;
        case (func)
            rhh_pkg::FN_INSERT, rhh_pkg::FN_INS_FIND: begin
                if (n_occ * 2 > SLOTS) a.status = rhh_pkg::ST_FULL;
                else a.status = place_key(key, value, home, func == rhh_pkg::FN_INS_FIND,
                                          where, val);
            end
            rhh_pkg::FN_FIND: begin
                if (probe_for(key, home, where)) begin
                    a.status = rhh_pkg::ST_FOUND;
                    val = tab_val[where];
                end
            end
            rhh_pkg::FN_REMOVE: begin
                if (probe_for(key, home, where)) begin
                    tab_occ[where] = 1'b0;
                    if (n_occ > 0) n_occ--;
                    a.status = rhh_pkg::ST_REMOVED;
                    val = tab_val[where];
                end
            end
            rhh_pkg::FN_CLEAR: begin
                wipe_table();
                a.status = rhh_pkg::ST_CLEARED;
            end
            default: ;
        endcase
        if (a.status inside {rhh_pkg::ST_NOT_FOUND, rhh_pkg::ST_FULL, rhh_pkg::ST_CLEARED}) begin
            where = 0;
            val = '0;
        end
        a.idx = where[5:0];
        a.value = val;
        a.count = n_occ[6:0];
        return a;
    endfunction

    // offer one request, hold it until taken, then maybe idle
    task automatic send_request(input logic [rhh_pkg::FUNC_W-1:0] func, input logic [63:0] key,
                                input logic [63:0] hash, input logic [31:0] value,
                                input bit typed, input t_answer typed_answer);
        t_answer a;
        int gap;
        int r;
        req.valid <= 1'b1;
        req.func <= func;
        req.key_word <= key;
        req.key_hash <= hash;
        req.new_value <= value;
        do @(posedge i_clk); while (!(req.valid && req.ready));
        a = apply_request(func, key, hash, value);
        answer_q.push_back(typed ? typed_answer : a);
        r = $urandom_range(0, 99);
        gap = quiet ? 0 : (r < 55) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int r;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (quiet) begin
                rsp.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    rsp.ready <= 1'b1;
                end else begin
                    rsp.ready <= 1'b0;
                    repeat ((r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40))
                        @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer e;
        if (rsp.valid && rsp.ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d slot %0d", $time,
                         rsp.status, rsp.slot_pos);
                errors++;
            end else begin
                e = answer_q.pop_front();
                if (rsp.status !== e.status) begin
                    $display("%0t: status expected %0d got %0d", $time, e.status, rsp.status);
                    errors++;
                end
                if (rsp.slot_pos !== e.idx) begin
                    $display("%0t: slot_pos expected %0d got %0d", $time, e.idx,
                             rsp.slot_pos);
                    errors++;
                end
                if (rsp.slot_value !== e.value) begin
                    $display("%0t: slot_value expected %h got %h", $time, e.value,
                             rsp.slot_value);
                    errors++;
                end
                if (rsp.entry_count !== e.count) begin
                    $display("%0t: entry_count expected %0d got %0d", $time, e.count,
                             rsp.entry_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row rows [$];
        t_answer none;
        logic [63:0] pool_key [POOL];
        logic [63:0] pool_hash [POOL];
        logic [rhh_pkg::FUNC_W-1:0] f;
        logic [63:0] k;
        logic [63:0] h;
        int r;
        int p;

        errors = 0;
        hold_off = 1'b0;
        quiet = 1'b0;
        idle_cycles = 0;
        none = '0;
        req.valid <= 1'b0;
        req.func <= rhh_pkg::FN_FIND;
        req.key_word <= '0;
        req.key_hash <= '0;
        req.new_value <= '0;
        wipe_table();

        rows.push_back('{rhh_pkg::FN_FIND, 64'd0, 64'd0, 32'd0, 1,
                         '{rhh_pkg::ST_NOT_FOUND, 6'd0, 32'd0, 7'd0}});
        rows.push_back('{rhh_pkg::FN_INSERT, ONES64, ONES64, 32'hffff_ffff, 1,
                         '{rhh_pkg::ST_INSERTED, 6'd63, 32'hffff_ffff, 7'd1}});
        rows.push_back('{rhh_pkg::FN_INSERT, 64'd0, 64'd0, 32'd0, 1,
                         '{rhh_pkg::ST_INSERTED, 6'd0, 32'd0, 7'd2}});
        rows.push_back('{rhh_pkg::FN_INSERT, ONES64, ONES64, 32'd5, 1,
                         '{rhh_pkg::ST_UPDATED, 6'd63, 32'd5, 7'd2}});
        rows.push_back('{rhh_pkg::FN_INS_FIND, ONES64, ONES64, 32'd9, 1,
                         '{rhh_pkg::ST_FOUND, 6'd63, 32'd5, 7'd2}});
        // collides at the top slot and wraps, displacing the entry at slot zero
        rows.push_back('{rhh_pkg::FN_INS_FIND, 64'd7, 64'd63, 32'hdead_beef, 0, none});
        rows.push_back('{rhh_pkg::FN_INSERT, 64'd8, 64'd63, 32'h1234_5678, 0, none});
        rows.push_back('{rhh_pkg::FN_FIND, 64'd0, 64'd0, 32'd0, 0, none});
        rows.push_back('{rhh_pkg::FN_REMOVE, ONES64, ONES64, 32'd0, 0, none});
        rows.push_back('{rhh_pkg::FN_FIND, ONES64, ONES64, 32'd0, 0, none});
        rows.push_back('{rhh_pkg::FN_REMOVE, ONES64, ONES64, 32'd0, 0, none});
        rows.push_back('{rhh_pkg::FN_INSERT, 64'd9, 64'h8000_0000_0000_003f, 32'h8000_0001, 0,
                         none});
        rows.push_back('{rhh_pkg::FN_FIND, 64'd7, 64'd63, 32'd0, 0, none});
        rows.push_back('{FN_RSVD_5, 64'd7, 64'd63, 32'd1, 0, none});
        rows.push_back('{FN_RSVD_6, ONES64, 64'd0, 32'd1, 0, none});
        rows.push_back('{FN_RSVD_7, 64'd0, ONES64, 32'd1, 0, none});
        rows.push_back('{rhh_pkg::FN_REMOVE, 64'd8, 64'd63, 32'd0, 0, none});
        rows.push_back('{rhh_pkg::FN_CLEAR, 64'd8, 64'd63, 32'd0, 1,
                         '{rhh_pkg::ST_CLEARED, 6'd0, 32'd0, 7'd0}});
        rows.push_back('{rhh_pkg::FN_FIND, 64'd7, 64'd63, 32'd0, 1,
                         '{rhh_pkg::ST_NOT_FOUND, 6'd0, 32'd0, 7'd0}});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_request(rows[i].func, rows[i].key, rows[i].hash, rows[i].value,
                         rows[i].typed, rows[i].answer);

        // key pool, homes clustered on a few slots half of the time
        for (int i = 0; i < POOL; i++) begin
            pool_key[i] = {$urandom, $urandom};
            pool_hash[i] = {$urandom, $urandom};
            if (i % 2 == 0) pool_hash[i][5:0] = 6'($urandom_range(20, 27));
        end

        for (int n = 0; n < RAND_REQS; n++) begin
            if (n == 250) hold_off = 1'b1;
            if (n == 500) begin
                req.valid <= 1'b0;
                wait (answer_q.size() == 0);
            end
            quiet = (n >= 550 && n < 650);
            r = $urandom_range(0, 99);
            f = (r < 38) ? rhh_pkg::FN_INSERT : (r < 56) ? rhh_pkg::FN_FIND :
                (r < 74) ? rhh_pkg::FN_REMOVE : (r < 95) ? rhh_pkg::FN_INS_FIND :
                (r < 97) ? rhh_pkg::FN_CLEAR : 3'($urandom_range(5, 7));
            p = $urandom_range(0, POOL - 1);
            r = $urandom_range(0, 99);
            k = (r < 90) ? pool_key[p] : {$urandom, $urandom};
            // a known key under a stray hash can leave a second copy in the table
            h = (r < 85) ? pool_hash[p] : {$urandom, $urandom};
            send_request(f, k, h, $urandom, 0, none);
        end
        req.valid <= 1'b0;
        quiet = 1'b0;

        wait (answer_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
